### sv/avf_pkg.sv
`default_nettype none
package avf_pkg;

  localparam int WINDOW_MAX_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ACCEL_W    = 16;
  localparam int CODE_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int FE_W       = 12;
  localparam int SP_W       = 24;
  localparam int DB_W       = 15;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int VEL_W      = 64;
  localparam int DISP_SHIFT = 25;
  localparam int CORR_FRAC  = 14;
  localparam int CORR_ONE   = 16384;
  localparam int NUM_FEAT   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 2'd2;

  localparam logic [FE_W-1:0] FE_RESET = 12'hFFF;
  localparam logic [SP_W-1:0] SP_RESET = 24'd167772;
  localparam logic [DB_W-1:0] DB_RESET = 15'd26;

  localparam logic [CODE_W-1:0] FC_MEAN_X  = 4'd0;
  localparam logic [CODE_W-1:0] FC_SD_X    = 4'd3;
  localparam logic [CODE_W-1:0] FC_CORR_XY = 4'd6;
  localparam logic [CODE_W-1:0] FC_CORR_XZ = 4'd7;
  localparam logic [CODE_W-1:0] FC_CORR_YZ = 4'd8;
  localparam logic [CODE_W-1:0] FC_DISP_X  = 4'd9;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      window_end;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0]         feature_code;
    logic signed [VALUE_W-1:0] feature_value;
    logic                      last_feature;
  } out_beat_t;

  typedef struct packed {
    logic mul;
    logic vel;
    logic lo;
    logic hi;
    logic disp;
    logic clr;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_VEL, ST_LO, ST_HI, ST_DISP,
    ST_RMUL, ST_RSTART, ST_RWAIT, ST_CMUL, ST_CPREP,
    ST_DSTART, ST_DWAIT, ST_EMIT
  } avf_state_t;

endpackage
`default_nettype wire

### sv/avf_lane.sv
`default_nettype none
module avf_lane
  import avf_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl,
  input  logic signed [SAMPLE_BITS-1:0] s_own,
  input  logic signed [SAMPLE_BITS-1:0] s_pa,
  input  logic signed [SAMPLE_BITS-1:0] s_pb,
  input  logic [SP_W-1:0]          period,
  input  logic [DB_W-1:0]          dead_band,
  output logic signed [SAMPLE_BITS+$clog2(WINDOW_MAX+1)-1:0]   sum,
  output logic signed [2*SAMPLE_BITS+$clog2(WINDOW_MAX+1)-1:0] sq_sum,
  output logic signed [2*SAMPLE_BITS+$clog2(WINDOW_MAX+1)-1:0] cross_sum,
  output logic signed [VEL_W-1:0]  disp
);

  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUMW  = SAMPLE_BITS + CW;
  localparam int PRODW = 2 * SAMPLE_BITS;
  localparam int SQW   = PRODW + CW;
  localparam int ACCW  = SAMPLE_BITS + SP_W + 1;
  localparam int MAGW  = VEL_W + 1;
  localparam int HIW   = MAGW - 32;
  localparam int PLOW  = 32 + SP_W;
  localparam int PHIW  = HIW + SP_W;
  localparam int FULLW = PHIW + 33;
  localparam int SHW   = FULLW - DISP_SHIFT;

  localparam logic signed [VEL_W-1:0] V_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] V_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  logic signed [PRODW-1:0] sq_r, cr_r;
  logic signed [ACCW-1:0]  acc_r;
  logic [MAGW-1:0]         mag_r;
  logic                    neg_r;
  logic [PLOW-1:0]         plo_r;
  logic [PHIW-1:0]         phi_r;
  logic signed [SUMW-1:0]  sum_r;
  logic signed [SQW-1:0]   sqs_r, crs_r;
  logic signed [VEL_W-1:0] vel_r, disp_r;

  logic [SAMPLE_BITS-1:0]  smag;
  logic signed [SAMPLE_BITS-1:0] a_in;
  logic signed [VEL_W:0]   vsum, tsum, dsum;
  logic signed [VEL_W-1:0] vnew, dval, dnew;
  logic [MAGW-1:0]         tmag;
  logic [FULLW-1:0]        full;
  logic [SHW-1:0]          shv;

  always_comb begin
    smag = s_own[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_own) : SAMPLE_BITS'(s_own);
    a_in = (32'(smag) < 32'(dead_band)) ? '0 : s_own;

    vsum = {vel_r[VEL_W-1], vel_r} + (VEL_W+1)'(acc_r);
    if (vsum[VEL_W] != vsum[VEL_W-1]) begin
      vnew = vsum[VEL_W] ? V_MIN : V_MAX;
    end else begin
      vnew = vsum[VEL_W-1:0];
    end
    tsum = {vel_r[VEL_W-1], vel_r} + {vnew[VEL_W-1], vnew};
    tmag = tsum[VEL_W] ? MAGW'(-tsum) : MAGW'(tsum);

    full = FULLW'({phi_r, 32'b0}) + FULLW'(plo_r);
    shv  = full[FULLW-1:DISP_SHIFT];
    if (|shv[SHW-1:VEL_W-1]) begin
      dval = neg_r ? V_MIN : V_MAX;
    end else begin
      dval = neg_r ? -$signed(shv[VEL_W-1:0]) : $signed(shv[VEL_W-1:0]);
    end
    dsum = {disp_r[VEL_W-1], disp_r} + {dval[VEL_W-1], dval};
    if (dsum[VEL_W] != dsum[VEL_W-1]) begin
      dnew = dsum[VEL_W] ? V_MIN : V_MAX;
    end else begin
      dnew = dsum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      sq_r  <= PRODW'(s_own) * PRODW'(s_own);
      cr_r  <= PRODW'(s_pa) * PRODW'(s_pb);
      acc_r <= ACCW'(a_in) * ACCW'($signed({1'b0, period}));
    end
    if (ctl.vel) begin
      mag_r <= tmag;
      neg_r <= tsum[VEL_W];
    end
    if (ctl.lo) plo_r <= PLOW'(mag_r[31:0]) * PLOW'(period);
    if (ctl.hi) phi_r <= PHIW'(mag_r[MAGW-1:32]) * PHIW'(period);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      sum_r  <= '0;
      sqs_r  <= '0;
      crs_r  <= '0;
      vel_r  <= '0;
      disp_r <= '0;
    end else begin
      if (ctl.vel) begin
        sum_r <= sum_r + SUMW'(s_own);
        sqs_r <= sqs_r + SQW'(sq_r);
        crs_r <= crs_r + SQW'(cr_r);
        vel_r <= vnew;
      end
      if (ctl.disp) disp_r <= dnew;
    end
  end

  assign sum       = sum_r;
  assign sq_sum    = sqs_r;
  assign cross_sum = crs_r;
  assign disp      = disp_r;

endmodule
`default_nettype wire

### sv/avf_div.sv
`default_nettype none
module avf_div
  import avf_pkg::*;
#(
  parameter int NUMW = 64,
  parameter int DENW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NUMW-1:0] q_r;
  logic [DENW-1:0] rem_r, den_r;
  logic [DENW:0]   rem_sh, rem_diff;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[NUMW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NUMW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_diff[DENW-1:0] : rem_sh[DENW-1:0];
      q_r   <= {q_r[NUMW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

### sv/avf_isqrt.sv
`default_nettype none
module avf_isqrt
  import avf_pkg::*;
#(
  parameter int RADW = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RADW-1:0]   rad,
  output logic              done,
  output logic [RADW/2-1:0] root
);

  localparam int RTW  = RADW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic            busy_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [RADW-1:0] rad_r;
  logic [RTW+1:0]  rem_r;
  logic [RTW-1:0]  root_r;
  logic [RTW+1:0]  rem_sh, trial;
  logic            ge;

  always_comb begin
    rem_sh = {rem_r[RTW-1:0], rad_r[RADW-1:RADW-2]};
    trial  = (RTW+2)'({root_r[RTW-2:0], 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(RTW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[RTW-2:0], ge};
      rad_r  <= {rad_r[RADW-3:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

### sv/accel_window_features.sv
// Sample beat: after acceptance, products, velocity and two-part displacement
//   multiply run in step on three lanes; input stalls until the block is idle.
// Window end: three square roots, then at most nine divisions on one shared
//   divider, then one result beat per unstalled cycle.
// Reset (rst_n low, synchronous) clears the window accumulators and counters
//   and loads the default register values; no clearing pass is needed.
`default_nettype none
module accel_window_features
  import avf_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int SQW  = 2 * SAMPLE_BITS + CW;
  localparam int RADW = 2 * ((CW + SQW + 1) / 2);
  localparam int RTW  = RADW / 2;
  localparam int COVW = CW + SQW + 2;
  localparam int NUMW = COVW + CORR_FRAC;
  localparam int DENW = 2 * RTW;
  localparam int EXTW = (SAMPLE_BITS > ACCEL_W) ? SAMPLE_BITS : ACCEL_W;
  localparam int SSW  = 2 * SUMW;

  function automatic logic [1:0] pair_a(input logic [1:0] k);
    pair_a = (k == 2'd2) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] pair_b(input logic [1:0] k);
    pair_b = (k == 2'd0) ? 2'd1 : 2'd2;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_mag(input logic [NUMW-1:0] q,
                                                        input logic neg);
    if (neg) begin
      sat_mag = (q >= NUMW'(33'h0_8000_0000)) ? {1'b1, {(VALUE_W-1){1'b0}}}
                                              : -$signed(q[VALUE_W-1:0]);
    end else begin
      sat_mag = (q > NUMW'(32'h7FFF_FFFF)) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                           : $signed(q[VALUE_W-1:0]);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] disp_feat(input logic signed [VEL_W-1:0] d);
    logic [VEL_W-1:0] m;
    m = d[VEL_W-1] ? VEL_W'(-d) : VEL_W'(d);
    m = m >> 16;
    if (d[VEL_W-1]) begin
      disp_feat = (m >= VEL_W'(33'h0_8000_0000)) ? {1'b1, {(VALUE_W-1){1'b0}}}
                                                 : -$signed(m[VALUE_W-1:0]);
    end else begin
      disp_feat = (m > VEL_W'(32'h7FFF_FFFF)) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                              : $signed(m[VALUE_W-1:0]);
    end
  endfunction

  avf_state_t state_r, state_nxt;
  lane_ctl_t  lane_ctl;

  logic [FE_W-1:0]  fe_r;
  logic [SP_W-1:0]  sp_r;
  logic [DB_W-1:0]  db_r;

  logic signed [SAMPLE_BITS-1:0] samp_r [3];
  logic                end_r;
  logic [CW-1:0]       count_r;
  logic [1:0]          ax_r;
  logic [CODE_W-1:0]   job_r;
  logic [CODE_W-1:0]   emit_r;
  logic [RADW-1:0]     t1_r, t2_r;
  logic [RTW-1:0]      root_r [3];
  logic signed [COVW-1:0] nc_r;
  logic signed [SSW-1:0]  ss_r;
  logic [DENW-1:0]     den_r;
  logic [COVW-1:0]     covmag_r;
  logic                covneg_r;
  logic signed [VALUE_W-1:0] val_r [9];
  out_beat_t           out_r;
  logic                out_valid_r;

  logic signed [SUMW-1:0]  lane_sum   [3];
  logic signed [SQW-1:0]   lane_sq    [3];
  logic signed [SQW-1:0]   lane_cross [3];
  logic signed [VEL_W-1:0] lane_disp  [3];
  logic [SUMW-1:0]         lane_mag   [3];

  logic signed [EXTW-1:0] ext_x, ext_y, ext_z;
  logic                sq_start, sq_done, div_start, div_done;
  logic [RADW-1:0]     rad;
  logic [RTW-1:0]      sq_root;
  logic [NUMW-1:0]     div_num, div_q;
  logic [DENW-1:0]     div_den;
  logic [CODE_W-1:0]   job_m3, job_m6, pick_m9;
  logic [1:0]          jx, kx;
  logic                win_done, out_free, found, more, last_job;
  logic [CODE_W-1:0]   pick;
  logic signed [VALUE_W-1:0] pick_val, div_res;
  logic signed [COVW-1:0] cov;
  logic [CORR_FRAC:0]  corr_mg;
  avf_state_t          job_next;

  assign ext_x = EXTW'(in_data.accel_x);
  assign ext_y = EXTW'(in_data.accel_y);
  assign ext_z = EXTW'(in_data.accel_z);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    avf_lane #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .s_own    (samp_r[l]),
      .s_pa     (samp_r[pair_a(2'(l))]),
      .s_pb     (samp_r[pair_b(2'(l))]),
      .period   (sp_r),
      .dead_band(db_r),
      .sum      (lane_sum[l]),
      .sq_sum   (lane_sq[l]),
      .cross_sum(lane_cross[l]),
      .disp     (lane_disp[l])
    );
    assign lane_mag[l] = lane_sum[l][SUMW-1] ? SUMW'(-lane_sum[l]) : SUMW'(lane_sum[l]);
  end

  avf_isqrt #(.RADW(RADW)) u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .rad  (rad),
    .done (sq_done),
    .root (sq_root)
  );

  avf_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  always_comb begin
    rad      = (t1_r >= t2_r) ? t1_r - t2_r : '0;
    win_done = end_r || (count_r == CW'(WINDOW_MAX));
    out_free = !out_valid_r || !out_stall;
    job_m3   = job_r - FC_SD_X;
    job_m6   = job_r - FC_CORR_XY;
    kx       = job_m6[1:0];
    if (job_r < FC_SD_X) begin
      jx      = job_r[1:0];
      div_num = NUMW'(lane_mag[jx]) + NUMW'(count_r >> 1);
      div_den = DENW'(count_r);
    end else if (job_r < FC_CORR_XY) begin
      jx      = job_m3[1:0];
      div_num = NUMW'(root_r[jx]);
      div_den = DENW'(count_r);
    end else begin
      jx      = kx;
      div_num = NUMW'({covmag_r, {CORR_FRAC{1'b0}}});
      div_den = den_r;
    end
    corr_mg = (div_q > NUMW'(CORR_ONE)) ? (CORR_FRAC+1)'(CORR_ONE) : div_q[CORR_FRAC:0];
    if (job_r < FC_SD_X) begin
      div_res = sat_mag(div_q, lane_sum[jx][SUMW-1]);
    end else if (job_r < FC_CORR_XY) begin
      div_res = sat_mag(div_q, 1'b0);
    end else begin
      div_res = covneg_r ? -VALUE_W'(corr_mg) : VALUE_W'(corr_mg);
    end
    cov      = nc_r - COVW'(ss_r);
    last_job = job_r == FC_CORR_YZ;
    if (last_job) begin
      job_next = ST_EMIT;
    end else if (job_r + 1'b1 >= FC_CORR_XY) begin
      job_next = ST_CMUL;
    end else begin
      job_next = ST_DSTART;
    end
  end

  always_comb begin
    found = 1'b0;
    more  = 1'b0;
    pick  = '0;
    for (int i = 0; i < NUM_FEAT; i++) begin
      if (fe_r[i] && (CODE_W'(i) >= emit_r)) begin
        if (found) begin
          more = 1'b1;
        end else begin
          found = 1'b1;
          pick  = CODE_W'(i);
        end
      end
    end
    pick_m9 = pick - FC_DISP_X;
    if (pick >= FC_DISP_X) begin
      pick_val = disp_feat(lane_disp[pick_m9[1:0]]);
    end else begin
      pick_val = val_r[pick];
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_ctl  = '0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        lane_ctl.mul = 1'b1;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        lane_ctl.vel = 1'b1;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        lane_ctl.lo = 1'b1;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        lane_ctl.hi = 1'b1;
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        lane_ctl.disp = 1'b1;
        state_nxt = win_done ? ST_RMUL : ST_IDLE;
      end
      ST_RMUL: state_nxt = ST_RSTART;
      ST_RSTART: begin
        sq_start  = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (sq_done) state_nxt = (ax_r == 2'd2) ? ST_DSTART : ST_RMUL;
      end
      ST_CMUL: state_nxt = ST_CPREP;
      ST_CPREP: state_nxt = (den_r == '0) ? job_next : ST_DSTART;
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) state_nxt = job_next;
      end
      ST_EMIT: begin
        if (out_free && !found) begin
          lane_ctl.clr = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fe_r        <= FE_RESET;
      sp_r        <= SP_RESET;
      db_r        <= DB_RESET;
      count_r     <= '0;
      ax_r        <= '0;
      job_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FEATURE_ENABLE: fe_r <= cfg_data[FE_W-1:0];
          REG_SAMPLE_PERIOD:  sp_r <= cfg_data[SP_W-1:0];
          REG_DEAD_BAND:      db_r <= cfg_data[DB_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_VEL) count_r <= count_r + 1'b1;
      if (lane_ctl.clr) count_r <= '0;
      if (state_r == ST_DISP) ax_r <= '0;
      if (state_r == ST_RWAIT && sq_done) begin
        ax_r <= ax_r + 1'b1;
        if (ax_r == 2'd2) job_r <= FC_MEAN_X;
      end
      if ((state_r == ST_DWAIT && div_done) || (state_r == ST_CPREP && den_r == '0)) begin
        job_r <= job_r + 1'b1;
        if (last_job) emit_r <= '0;
      end
      if (state_r == ST_EMIT && out_free && found) begin
        out_valid_r <= 1'b1;
        emit_r      <= pick + 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      samp_r[0] <= ext_x[SAMPLE_BITS-1:0];
      samp_r[1] <= ext_y[SAMPLE_BITS-1:0];
      samp_r[2] <= ext_z[SAMPLE_BITS-1:0];
      end_r     <= in_data.window_end;
    end
    if (state_r == ST_RMUL) begin
      t1_r <= RADW'(count_r) * RADW'($unsigned(lane_sq[ax_r]));
      t2_r <= RADW'(lane_mag[ax_r]) * RADW'(lane_mag[ax_r]);
    end
    if (state_r == ST_RWAIT && sq_done) root_r[ax_r] <= sq_root;
    if (state_r == ST_CMUL) begin
      nc_r  <= COVW'($signed({1'b0, count_r})) * COVW'(lane_cross[kx]);
      ss_r  <= SSW'(lane_sum[pair_a(kx)]) * SSW'(lane_sum[pair_b(kx)]);
      den_r <= DENW'(root_r[pair_a(kx)]) * DENW'(root_r[pair_b(kx)]);
    end
    if (state_r == ST_CPREP) begin
      covneg_r <= cov[COVW-1];
      covmag_r <= cov[COVW-1] ? COVW'(-cov) : COVW'(cov);
      if (den_r == '0) val_r[job_r] <= '0;
    end
    if (state_r == ST_DWAIT && div_done) val_r[job_r] <= div_res;
    if (state_r == ST_EMIT && out_free && found) begin
      out_r.feature_code  <= pick;
      out_r.feature_value <= pick_val;
      out_r.last_feature  <= !more;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_feature |-> ((fe_r >> out_data.feature_code) >> 1) == '0)
    else $error("last beat is not the highest enabled feature");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_MAX))
    else $error("sample count passed window limit");
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.feature_code == FC_CORR_XY || out_data.feature_code == FC_CORR_XZ ||
                  out_data.feature_code == FC_CORR_YZ)
    |-> out_data.feature_value <= 32'sd16384 && out_data.feature_value >= -32'sd16384)
    else $error("correlation out of range");
`endif

endmodule
`default_nettype wire
